// ===== src/k_of_n_repairable_equivalent_rates_core_defines.svh =====
// Assertion macros for the k-of-n equivalent rates core.
// Used by the top level; depends on clk and rst_n in the including scope.
`ifndef K_OF_N_REPAIRABLE_EQUIVALENT_RATES_CORE_DEFINES_SVH
`define K_OF_N_REPAIRABLE_EQUIVALENT_RATES_CORE_DEFINES_SVH

// clocked check, disabled during reset
`define KNER_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define KNER_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/kner_pkg.sv =====
// Shared types and constants for the k-of-n equivalent rates core.
// No dependencies.
package kner_pkg;

  localparam int P_W    = 64;
  localparam int RATE_W = 32;

  localparam logic [P_W-1:0] P_ONE = 64'h0000_0001_0000_0000;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_ZDIV  = 2'd1,
    ERR_RANGE = 2'd2
  } kner_err_t;

  typedef enum logic [1:0] {
    RULE_ONE    = 2'd0,
    RULE_ALL    = 2'd1,
    RULE_NEEDED = 2'd2
  } kner_rule_t;

  typedef struct packed {
    logic busy;
    logic done;
  } kner_md_stat_t;

endpackage

// ===== src/kner_if.sv =====
// Request and result channel interfaces for the k-of-n equivalent rates core.
// No package dependency.
interface kner_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  unit_count;
  logic [1:0]  rule_kind;
  logic [5:0]  needed_units;
  logic [5:0]  state_limit;
  logic [5:0]  repair_crews;
  logic        load_shared;
  logic [31:0] unit_fail_rate;
  logic [31:0] unit_repair_rate;
  modport source (output valid, unit_count, rule_kind, needed_units, state_limit,
                  repair_crews, load_shared, unit_fail_rate, unit_repair_rate,
                  input ready);
  modport sink (input valid, unit_count, rule_kind, needed_units, state_limit,
                repair_crews, load_shared, unit_fail_rate, unit_repair_rate,
                output ready);
endinterface

interface kner_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] group_fail_rate;
  logic [31:0] group_repair_rate;
  logic [1:0]  error_code;
  modport source (output valid, group_fail_rate, group_repair_rate, error_code,
                  input ready);
  modport sink (input valid, group_fail_rate, group_repair_rate, error_code,
                output ready);
endinterface

// ===== src/k_of_n_repairable_equivalent_rates_core.sv =====
// Equivalent failure/repair rates of a repairable k-of-n group.
// Each weight step runs start, multiply, check, divide and done in turn (the divide is skipped when the
// quotient saturates), for state_limit+1 steps plus two final quotients from accept to result.
// Throughput: one request at a time; in ready only while idle.
// Reset: synchronous active-low rst_n returns sequencer and divider to idle.
// Depends on kner_pkg, kner_if, kner_muldiv and the defines header.
`include "k_of_n_repairable_equivalent_rates_core_defines.svh"
module k_of_n_repairable_equivalent_rates_core import kner_pkg::*; #(
  parameter int MAX_UNITS  = 32,
  parameter int MAX_STATES = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  kner_in_if.sink  in_req,
  kner_out_if.source out_rsp
);

  localparam int WW  = $clog2(MAX_UNITS + 1);
  localparam int IW  = $clog2(MAX_STATES + 2);
  localparam int MW  = (WW > IW) ? WW : IW;
  localparam int Y_W = RATE_W + MW;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_STEP  = 8'b0000_0010,
    S_WAIT  = 8'b0000_0100,
    S_FIN1  = 8'b0000_1000,
    S_WAIT1 = 8'b0001_0000,
    S_FIN2  = 8'b0010_0000,
    S_WAIT2 = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t              state_r;
  logic [5:0]          m_r, k_r, lim_r, crews_r, d_r;
  logic                shared_r;
  logic [RATE_W-1:0]   lam_r, mu_r;
  logic [IW-1:0]       i_r;
  logic [P_W-1:0]      p_r, sum1_r, sum2_r, pd_r, pd1_r;
  logic [RATE_W-1:0]   fail_r, rep_r;
  kner_err_t           err_r;

  // request decode
  logic [5:0]  m_c, lim_c, k_c;
  logic [7:0]  dif_c;
  logic        bad_range, bad_div;

  always_comb begin
    m_c   = (32'(in_req.unit_count) > MAX_UNITS) ? 6'(MAX_UNITS) : in_req.unit_count;
    lim_c = (32'(in_req.state_limit) > MAX_STATES) ? 6'(MAX_STATES) : in_req.state_limit;
    case (kner_rule_t'(in_req.rule_kind))
      RULE_ONE:    k_c = 6'd1;
      RULE_ALL:    k_c = m_c;
      RULE_NEEDED: k_c = in_req.needed_units;
      default:     k_c = 6'd0;
    endcase
    dif_c     = {2'b00, m_c} - {2'b00, k_c};
    bad_range = dif_c[7] || (dif_c > {2'b00, lim_c});
    bad_div   = (in_req.repair_crews == 6'd0) || (in_req.unit_repair_rate == '0);
  end

  // birth-death rates at one index
  logic [IW-1:0]   idx;
  logic [7:0]      w8;
  logic [WW-1:0]   w;
  logic [IW-1:0]   c;
  logic [Y_W-1:0]  rate_a, rate_b;

  always_comb begin
    idx = (state_r == S_STEP) ? i_r : IW'({2'b00, d_r} + 8'd1);
    w8  = {2'b00, m_r} + 8'd1 - 8'(idx);
    if (8'(idx) > {2'b00, m_r} + 8'd1) w8 = 8'd0;
    if (shared_r && (w8 >= {2'b00, k_r})) w8 = {2'b00, k_r};
    w   = WW'(w8);
    c   = (8'(idx) <= {2'b00, crews_r}) ? idx : IW'(crews_r);
    rate_a = Y_W'(w) * Y_W'(lam_r);
    rate_b = Y_W'(c) * Y_W'(mu_r);
  end

  // shared multiply-divide
  logic            md_start;
  logic [P_W-1:0]  md_x, md_d, md_res;
  logic [Y_W-1:0]  md_y;
  kner_md_stat_t   md_stat;

  always_comb begin
    md_start = (state_r == S_STEP) || (state_r == S_FIN1) || (state_r == S_FIN2);
    case (state_r)
      S_FIN1: begin
        md_x = pd_r;  md_y = rate_a; md_d = sum1_r;
      end
      S_FIN2: begin
        md_x = pd1_r; md_y = rate_b; md_d = sum2_r;
      end
      default: begin
        md_x = p_r;   md_y = rate_a; md_d = P_W'(rate_b);
      end
    endcase
  end

  kner_muldiv #(.Y_W(Y_W)) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .x     (md_x),
    .y     (md_y),
    .dv    (md_d),
    .stat  (md_stat),
    .res   (md_res)
  );

  function automatic logic [P_W-1:0] add_sat(input logic [P_W-1:0] a, input logic [P_W-1:0] b);
    logic [P_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[P_W] ? '1 : s[P_W-1:0];
  endfunction

  function automatic logic [RATE_W-1:0] clamp32(input logic [P_W-1:0] v);
    return (v[P_W-1:RATE_W] != '0) ? '1 : v[RATE_W-1:0];
  endfunction

  logic [7:0] ie, de, le;
  assign ie = 8'(i_r);
  assign de = {2'b00, d_r};
  assign le = {2'b00, lim_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_req.valid) begin
          if (bad_range || bad_div) state_r <= S_OUT;
          else state_r <= S_STEP;
        end
        S_STEP: state_r <= S_WAIT;
        S_WAIT: if (md_stat.done) begin
          if (ie == le + 8'd1) state_r <= (sum2_r == '0) ? S_OUT : S_FIN1;
          else state_r <= S_STEP;
        end
        S_FIN1:  state_r <= S_WAIT1;
        S_WAIT1: if (md_stat.done) state_r <= S_FIN2;
        S_FIN2:  state_r <= S_WAIT2;
        S_WAIT2: if (md_stat.done) state_r <= S_OUT;
        S_OUT:   if (out_rsp.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        m_r      <= m_c;
        k_r      <= k_c;
        lim_r    <= lim_c;
        crews_r  <= in_req.repair_crews;
        shared_r <= in_req.load_shared;
        lam_r    <= in_req.unit_fail_rate;
        mu_r     <= in_req.unit_repair_rate;
        d_r      <= dif_c[5:0];
        i_r      <= IW'(1);
        p_r      <= P_ONE;
        sum1_r   <= P_ONE;
        sum2_r   <= '0;
        pd_r     <= P_ONE;
        fail_r   <= '0;
        rep_r    <= '0;
        err_r    <= bad_range ? ERR_RANGE : (bad_div ? ERR_ZDIV : ERR_NONE);
      end
      S_WAIT: if (md_stat.done) begin
        p_r <= md_res;
        if (ie <= de) sum1_r <= add_sat(sum1_r, md_res);
        else if (ie <= le) sum2_r <= add_sat(sum2_r, md_res);
        if (ie == de) pd_r <= md_res;
        if (ie == de + 8'd1) pd1_r <= md_res;
        i_r <= i_r + IW'(1);
        if ((ie == le + 8'd1) && (sum2_r == '0)) err_r <= ERR_ZDIV;
      end
      S_WAIT1: if (md_stat.done) fail_r <= clamp32(md_res);
      S_WAIT2: if (md_stat.done) rep_r <= clamp32(md_res);
      default: ;
    endcase
  end

  assign in_req.ready              = (state_r == S_IDLE);
  assign out_rsp.valid             = (state_r == S_OUT);
  assign out_rsp.group_fail_rate   = (err_r == ERR_NONE) ? fail_r : '0;
  assign out_rsp.group_repair_rate = (err_r == ERR_NONE) ? rep_r : '0;
  assign out_rsp.error_code        = err_r;

  `KNER_ASSERT(a_ready_excl, in_req.ready |-> !out_rsp.valid, "ready while result pending")
  `KNER_ASSERT(a_start_idle, md_start |-> !md_stat.busy, "muldiv started while busy")
  `KNER_ASSERT(a_done_busy, md_stat.done |-> $past(md_stat.busy), "muldiv done without work")
  `KNER_ASSERT(a_err_zero, (out_rsp.valid && (out_rsp.error_code != ERR_NONE)) |-> ((out_rsp.group_fail_rate == '0) && (out_rsp.group_repair_rate == '0)), "error result with nonzero rate")
  `KNER_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_rsp.valid, "result valid after reset")

endmodule

// ===== src/kner_muldiv.sv =====
// Shared serial multiply-divide unit: (x * y) / dv, truncated, saturated to 64 bits.
// Shift-add multiply one bit per cycle, restoring divide one bit per cycle. Uses kner_pkg.
module kner_muldiv import kner_pkg::*; #(
  parameter int Y_W = 38
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [P_W-1:0]   x,
  input  logic [Y_W-1:0]   y,
  input  logic [P_W-1:0]   dv,
  output kner_md_stat_t    stat,
  output logic [P_W-1:0]   res
);

  typedef enum logic [3:0] {
    MD_IDLE = 4'b0001,
    MD_MUL  = 4'b0010,
    MD_CHK  = 4'b0100,
    MD_DIV  = 4'b1000
  } md_state_t;

  md_state_t            state_r, state_nxt;
  logic [P_W-1:0]       x_r;
  logic [Y_W-1:0]       y_r;
  logic [P_W-1:0]       d_r;
  logic [2*P_W-1:0]     acc_r;
  logic [5:0]           cnt_r;
  logic [P_W-1:0]       res_r;
  logic                 done_r;
  logic [P_W:0]         rem_sh;
  logic                 take;

  assign rem_sh = {acc_r[2*P_W-1:P_W], acc_r[P_W-1]};
  assign take   = (rem_sh >= {1'b0, d_r});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MD_IDLE: if (start) state_nxt = MD_MUL;
      MD_MUL:  if (cnt_r == 6'(Y_W - 1)) state_nxt = MD_CHK;
      MD_CHK:  state_nxt = (acc_r[2*P_W-1:P_W] >= d_r) ? MD_IDLE : MD_DIV;
      MD_DIV:  if (cnt_r == 6'(P_W - 1)) state_nxt = MD_IDLE;
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= ((state_r == MD_CHK) && (acc_r[2*P_W-1:P_W] >= d_r)) ||
                 ((state_r == MD_DIV) && (cnt_r == 6'(P_W - 1)));
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      MD_IDLE: begin
        x_r   <= x;
        y_r   <= y;
        d_r   <= dv;
        acc_r <= '0;
        cnt_r <= '0;
      end
      MD_MUL: begin
        acc_r <= (acc_r << 1) + (y_r[Y_W-1] ? {{P_W{1'b0}}, x_r} : '0);
        y_r   <= y_r << 1;
        cnt_r <= (cnt_r == 6'(Y_W - 1)) ? 6'd0 : cnt_r + 6'd1;
      end
      MD_CHK: begin
        if (acc_r[2*P_W-1:P_W] >= d_r) res_r <= '1;
      end
      MD_DIV: begin
        acc_r[2*P_W-1:P_W] <= take ? P_W'(rem_sh - {1'b0, d_r}) : rem_sh[P_W-1:0];
        acc_r[P_W-1:0]     <= {acc_r[P_W-2:0], take};
        cnt_r              <= cnt_r + 6'd1;
        if (cnt_r == 6'(P_W - 1)) res_r <= {acc_r[P_W-2:0], take};
      end
      default: ;
    endcase
  end

  assign stat.busy = (state_r != MD_IDLE);
  assign stat.done = done_r;
  assign res       = res_r;

endmodule

// ===== bench/kner_tb_if.sv =====
`timescale 1ns / 1ps
// Testbench-side note: the channel interfaces come from the RTL's kner_if.sv.
// This file holds the bench's request and result record types; depends on kner_pkg.
package kner_tb_pkg;
  import kner_pkg::*;

  typedef struct packed {
    logic [5:0]  unit_count;
    logic [1:0]  rule_kind;
    logic [5:0]  needed_units;
    logic [5:0]  state_limit;
    logic [5:0]  repair_crews;
    logic        load_shared;
    logic [31:0] unit_fail_rate;
    logic [31:0] unit_repair_rate;
  } group_req_t;

  typedef struct packed {
    logic [31:0] group_fail_rate;
    logic [31:0] group_repair_rate;
    kner_err_t   error_code;
  } group_rates_t;
endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Top-level bench for k_of_n_repairable_equivalent_rates_core: random and directed
// group requests, bursty sender, stalling receiver, in-bench rate predictor.
// Depends on kner_pkg, kner_if (RTL) and kner_tb_pkg.
module tb_top;
  import kner_pkg::*;
  import kner_tb_pkg::*;

  localparam int UNITS_CAP  = 32;
  localparam int STATES_CAP = 32;
  localparam longint CYCLE_LIMIT = 10_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycle_cnt = 0;
  int   fail_cnt = 0;
  bit   stim_done = 1'b0;

  kner_in_if  req_ch ();
  kner_out_if rsp_ch ();

  k_of_n_repairable_equivalent_rates_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch.sink),
    .out_rsp(rsp_ch.source)
  );

  always #5 clk = ~clk;

  group_req_t   pending_reqs[$];
  group_rates_t expected_rates[$];
  int           reqs_sent = 0;

  function automatic logic [63:0] muldiv_sat(logic [63:0] x, logic [63:0] y,
                                             logic [63:0] d);
    logic [127:0] prod;
    logic [127:0] q;
    prod = 128'(x) * 128'(y);
    q = prod / 128'(d);
    return (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
  endfunction

  function automatic logic [63:0] add_sat64(logic [63:0] x, logic [63:0] y);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  function automatic group_rates_t predict_rates(group_req_t r);
    group_rates_t res;
    int m, k, d, lim, w, c;
    logic [63:0] up[STATES_CAP+2];
    logic [63:0] down[STATES_CAP+2];
    logic [63:0] wt[STATES_CAP+2];
    logic [63:0] sum_up, sum_dn, v;
    res = '0;
    res.error_code = ERR_NONE;
    m = (r.unit_count > UNITS_CAP) ? UNITS_CAP : r.unit_count;
    lim = (r.state_limit > STATES_CAP) ? STATES_CAP : r.state_limit;
    case (r.rule_kind)
      RULE_ONE: k = 1;
      RULE_ALL: k = m;
      RULE_NEEDED: k = r.needed_units;
      default: k = 0;
    endcase
    d = m - k;
    if (d < 0 || d > lim) begin
      res.error_code = ERR_RANGE;
      return res;
    end
    if (r.repair_crews == 0 || r.unit_repair_rate == 0) begin
      res.error_code = ERR_ZDIV;
      return res;
    end
    for (int i = 1; i <= lim + 1; i++) begin
      w = m - i + 1;
      if (w < 0) w = 0;
      if (r.load_shared && w >= k) w = k;
      up[i] = 64'(w) * 64'(r.unit_fail_rate);
      c = (i <= r.repair_crews) ? i : r.repair_crews;
      down[i] = 64'(c) * 64'(r.unit_repair_rate);
    end
    wt[0] = P_ONE;
    for (int i = 1; i <= lim + 1; i++) wt[i] = muldiv_sat(wt[i-1], up[i], down[i]);
    sum_up = 0;
    sum_dn = 0;
    for (int i = 0; i <= d; i++) sum_up = add_sat64(sum_up, wt[i]);
    for (int i = d + 1; i <= lim; i++) sum_dn = add_sat64(sum_dn, wt[i]);
    if (sum_dn == 0) begin
      res.error_code = ERR_ZDIV;
      return res;
    end
    v = muldiv_sat(wt[d], up[d+1], sum_up);
    res.group_fail_rate = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    v = muldiv_sat(wt[d+1], down[d+1], sum_dn);
    res.group_repair_rate = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    return res;
  endfunction

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 32'h0001_0000);
      3: return $urandom_range(32'h0001_0000, 32'h0100_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic group_req_t random_req();
    group_req_t r;
    r.unit_count = $urandom_range(1, 8) == 1 ? 6'($urandom) : 6'($urandom_range(1, 32));
    r.rule_kind = $urandom_range(0, 15) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
    r.needed_units = $urandom_range(0, 7) == 0 ? 6'($urandom) :
                     6'($urandom_range(1, (r.unit_count > 32) ? 32 : r.unit_count));
    r.state_limit = $urandom_range(0, 7) == 0 ? 6'($urandom) : 6'($urandom_range(0, 32));
    if ($urandom_range(0, 2) == 0) r.state_limit = 6'($urandom_range(0, 6));
    r.repair_crews = $urandom_range(0, 9) == 0 ? 6'($urandom) : 6'($urandom_range(1, 32));
    r.load_shared = 1'($urandom);
    r.unit_fail_rate = $urandom_range(0, 3) == 0 ? 32'($urandom) : pick_rate();
    r.unit_repair_rate = $urandom_range(0, 3) == 0 ? 32'($urandom) : pick_rate();
    return r;
  endfunction

  function automatic group_req_t make_req(int m, logic [1:0] rk, int kk, int lim,
                                          int crews, bit sh, logic [31:0] lam,
                                          logic [31:0] mu);
    group_req_t r;
    r.unit_count = 6'(m);
    r.rule_kind = rk;
    r.needed_units = 6'(kk);
    r.state_limit = 6'(lim);
    r.repair_crews = 6'(crews);
    r.load_shared = sh;
    r.unit_fail_rate = lam;
    r.unit_repair_rate = mu;
    return r;
  endfunction

  function automatic void queue_req(group_req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  initial begin
    group_req_t r;
    queue_req(make_req(2, RULE_ONE, 0, 2, 1, 0, 32'h0001_0000, 32'h0001_0000));
    queue_req(make_req(3, RULE_ALL, 0, 3, 2, 1, 32'h0000_8000, 32'h0002_0000));
    queue_req(make_req(5, RULE_NEEDED, 3, 4, 1, 1, 32'h0000_1000, 32'h0001_0000));
    queue_req(make_req(32, RULE_ONE, 0, 32, 32, 0, 32'hFFFF_FFFF, 32'h0000_0001));
    queue_req(make_req(63, RULE_ONE, 0, 63, 63, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    queue_req(make_req(1, RULE_ONE, 0, 0, 1, 0, 32'h1, 32'h1));
    queue_req(make_req(4, RULE_NEEDED, 4, 0, 1, 0, 32'h1000, 32'h1000));
    queue_req(make_req(4, RULE_NEEDED, 5, 3, 1, 0, 32'h1000, 32'h1000));
    queue_req(make_req(10, RULE_NEEDED, 2, 3, 1, 0, 32'h1000, 32'h1000));
    queue_req(make_req(4, 2'd3, 0, 6, 2, 0, 32'h1000, 32'h1000));
    queue_req(make_req(4, 2'd3, 0, 4, 2, 0, 32'h1000, 32'h1000));
    queue_req(make_req(4, RULE_ONE, 0, 3, 1, 0, 32'h1000, 32'h1000));
    queue_req(make_req(6, RULE_ONE, 0, 6, 0, 0, 32'h1000, 32'h1000));
    queue_req(make_req(6, RULE_ONE, 0, 6, 2, 0, 32'h1000, 32'h0));
    queue_req(make_req(6, RULE_ALL, 0, 5, 3, 0, 32'h0, 32'h1000));
    queue_req(make_req(8, RULE_NEEDED, 0, 8, 2, 1, 32'h2_0000, 32'h1_0000));
    queue_req(make_req(20, RULE_NEEDED, 18, 2, 63, 1, 32'hFFFF_FFFF, 32'h1));
    queue_req(make_req(2, RULE_ONE, 63, 1, 2, 1, 32'h8000_0000, 32'h7FFF_FFFF));
    queue_req(make_req(3, RULE_NEEDED, 1, 40, 5, 0, 32'h1234_5678, 32'h9ABC_DEF0));
    for (int n = 0; n < 300; n++) begin
      r = random_req();
      queue_req(r);
    end
  end

  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_rates.insert(expected_rates.size(), predict_rates(pending_reqs.pop_front()));
        reqs_sent <= reqs_sent + 1;
      end
      if (req_ch.valid && !req_ch.ready) begin
        // hold the request
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_ch.valid <= 1'b1;
        {req_ch.unit_count, req_ch.rule_kind, req_ch.needed_units, req_ch.state_limit,
         req_ch.repair_crews, req_ch.load_shared, req_ch.unit_fail_rate,
         req_ch.unit_repair_rate} <= pending_reqs[0];
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 6);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
        end
      end else begin
        req_ch.valid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  int hold_off = 0;
  bit long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!long_hold_done && reqs_sent == 40) begin
      long_hold_done <= 1'b1;
      hold_off <= 20000;
      rsp_ch.ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: rsp_ch.ready <= 1'b0;
        2: begin
          rsp_ch.ready <= 1'b0;
          hold_off <= $urandom_range(1, 300);
        end
        default: rsp_ch.ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    group_rates_t want;
    bit bad;
    bad = 1'b0;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rates.size() == 0) begin
        $error("unexpected result: fail=%h repair=%h err=%0d", rsp_ch.group_fail_rate,
               rsp_ch.group_repair_rate, rsp_ch.error_code);
        bad = 1'b1;
      end else begin
        want = expected_rates.pop_front();
        if (rsp_ch.group_fail_rate !== want.group_fail_rate) begin
          $error("group_fail_rate: expected %h actual %h", want.group_fail_rate,
                 rsp_ch.group_fail_rate);
          bad = 1'b1;
        end
        if (rsp_ch.group_repair_rate !== want.group_repair_rate) begin
          $error("group_repair_rate: expected %h actual %h", want.group_repair_rate,
                 rsp_ch.group_repair_rate);
          bad = 1'b1;
        end
        if (rsp_ch.error_code !== want.error_code) begin
          $error("error_code: expected %0d actual %0d", want.error_code,
                 rsp_ch.error_code);
          bad = 1'b1;
        end
      end
    end
    if (bad) fail_cnt <= fail_cnt + 1;
  end

  initial begin
    req_ch.valid = 1'b0;
    {req_ch.unit_count, req_ch.rule_kind, req_ch.needed_units, req_ch.state_limit,
     req_ch.repair_crews, req_ch.load_shared, req_ch.unit_fail_rate,
     req_ch.unit_repair_rate} = '0;
    rsp_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    wait (stim_done && expected_rates.size() == 0 && !req_ch.valid);
    repeat (4000) @(posedge clk);
    if (fail_cnt == 0 && expected_rates.size() == 0)
      $display("k_of_n_repairable_equivalent_rates_core regression: pass");
    else
      $display("k_of_n_repairable_equivalent_rates_core regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("k_of_n_repairable_equivalent_rates_core regression: fail");
      $finish;
    end
  end
endmodule
